// ===== hw/rtl/mdd_pkg.sv =====
`default_nettype none

package mdd_pkg;

  localparam int PNL_WIDTH     = 32;
  localparam int STAMP_WIDTH   = 32;
  localparam int DD_OUT_WIDTH  = 48;
  localparam int DEF_SUM_WIDTH = 48;

  typedef logic [STAMP_WIDTH-1:0] stamp_t;

  // Per-series bookkeeping carried next to the sums.
  typedef struct packed {
    logic   pending_drop;
    logic   first_pending;
    logic   any_recovered;
    stamp_t peak_stamp;
    stamp_t begin_stamp;
    stamp_t return_stamp;
  } mdd_flags_t;

  localparam mdd_flags_t FLAGS_RESET = '{
    pending_drop:  1'b0,
    first_pending: 1'b1,
    any_recovered: 1'b0,
    peak_stamp:    '0,
    begin_stamp:   '0,
    return_stamp:  '0
  };

endpackage

`default_nettype wire

// ===== hw/rtl/mdd_in_if.sv =====
`default_nettype none

interface mdd_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [mdd_pkg::PNL_WIDTH-1:0]   pnl_delta;
  logic        [mdd_pkg::STAMP_WIDTH-1:0] stamp;
  logic                                   series_start;

  modport source (output valid, pnl_delta, stamp, series_start, input ready);
  modport sink   (input valid, pnl_delta, stamp, series_start, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mdd_out_if.sv =====
`default_nettype none

interface mdd_out_if;
  logic                                    valid;
  logic                                    ready;
  logic [mdd_pkg::DD_OUT_WIDTH-1:0]        max_drawdown;
  logic                                    recovered;
  logic [mdd_pkg::STAMP_WIDTH-1:0]         drop_begin;
  logic [mdd_pkg::STAMP_WIDTH-1:0]         drop_return;

  modport source (output valid, max_drawdown, recovered, drop_begin, drop_return,
                  input ready);
  modport sink   (input valid, max_drawdown, recovered, drop_begin, drop_return,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mdd_update.sv =====
`default_nettype none

module mdd_update #(
  parameter int SUM_WIDTH = mdd_pkg::DEF_SUM_WIDTH
) (
  input  wire logic                                  start,
  input  wire logic signed [mdd_pkg::PNL_WIDTH-1:0]  pnl_delta,
  input  wire mdd_pkg::stamp_t                       stamp,
  input  wire logic signed [SUM_WIDTH-1:0]           equity,
  input  wire logic signed [SUM_WIDTH-1:0]           peak,
  input  wire logic signed [SUM_WIDTH-1:0]           trough,
  input  wire logic        [SUM_WIDTH-1:0]           deepest,
  input  wire mdd_pkg::mdd_flags_t                   flags,
  output logic signed      [SUM_WIDTH-1:0]           equity_nxt,
  output logic signed      [SUM_WIDTH-1:0]           peak_nxt,
  output logic signed      [SUM_WIDTH-1:0]           trough_nxt,
  output logic             [SUM_WIDTH-1:0]           deepest_nxt,
  output mdd_pkg::mdd_flags_t                        flags_nxt,
  output logic [mdd_pkg::DD_OUT_WIDTH-1:0]           dd_out
);

  localparam int W = SUM_WIDTH;
  localparam logic signed [W-1:0] SUM_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SUM_MIN = {1'b1, {(W-1){1'b0}}};

  logic signed [W-1:0] eq_b;
  logic signed [W-1:0] peak_b;
  logic signed [W-1:0] trough_b;
  logic        [W-1:0] deep_b;
  mdd_pkg::mdd_flags_t flags_b;
  logic signed [W:0]   sum_x;
  logic        [W-1:0] drop;

  always_comb begin
    // series start: process against the post-reset state
    eq_b     = start ? '0 : equity;
    peak_b   = start ? '0 : peak;
    trough_b = start ? '0 : trough;
    deep_b   = start ? '0 : deepest;
    flags_b  = start ? mdd_pkg::FLAGS_RESET : flags;

    if (flags_b.first_pending) begin
      flags_b.peak_stamp = stamp;
    end
    flags_b.first_pending = 1'b0;

    sum_x = (W+1)'(eq_b) + (W+1)'(pnl_delta);
    if (sum_x[W] != sum_x[W-1]) begin
      equity_nxt = sum_x[W] ? SUM_MIN : SUM_MAX;
    end else begin
      equity_nxt = sum_x[W-1:0];
    end

    peak_nxt    = peak_b;
    trough_nxt  = trough_b;
    deepest_nxt = deep_b;
    flags_nxt   = flags_b;
    drop        = $unsigned(peak_b) - $unsigned(equity_nxt);

    if (equity_nxt > peak_b) begin
      peak_nxt   = equity_nxt;
      trough_nxt = equity_nxt;
      if (flags_b.pending_drop) begin
        flags_nxt.begin_stamp   = flags_b.peak_stamp;
        flags_nxt.return_stamp  = stamp;
        flags_nxt.pending_drop  = 1'b0;
        flags_nxt.any_recovered = 1'b1;
      end
      flags_nxt.peak_stamp = stamp;
    end else if (trough_b > equity_nxt) begin
      trough_nxt = equity_nxt;
      if (drop > deep_b) begin
        deepest_nxt            = drop;
        flags_nxt.pending_drop = 1'b1;
      end
    end
  end

  generate
    if (W > mdd_pkg::DD_OUT_WIDTH) begin : g_dd_sat
      assign dd_out = (|deepest_nxt[W-1:mdd_pkg::DD_OUT_WIDTH]) ? '1
                    : deepest_nxt[mdd_pkg::DD_OUT_WIDTH-1:0];
    end else begin : g_dd_ext
      assign dd_out = mdd_pkg::DD_OUT_WIDTH'(deepest_nxt);
    end
  endgenerate

endmodule

`default_nettype wire

// ===== hw/rtl/max_drawdown_tracker_core.sv =====
`default_nettype none

// Channel  Dir  Payload                                              Transfer
// in_chan  in   pnl_delta[31:0] s, stamp[31:0], series_start         valid & ready
// out_chan out  max_drawdown[47:0], recovered, drop_begin[31:0],     valid & ready
//               drop_return[31:0]
//
// One item per cycle sustained while out_chan is not stalled; each item passes
// through the input register and then the result register. The rate is set by the
// state update (one saturating add, compares, one subtract), which is combinational
// from the input register to the result register. Synchronous active-low reset
// clears the valid flags and the series state. A stalled output holds the item in
// the input register and in_chan.ready drops only when both registers are full.

module max_drawdown_tracker_core #(
  parameter int SUM_WIDTH = mdd_pkg::DEF_SUM_WIDTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  mdd_in_if.sink    in_chan,
  mdd_out_if.source out_chan
);

  localparam int W = SUM_WIDTH;

  // input register
  logic                                  s1_valid_r;
  logic signed [mdd_pkg::PNL_WIDTH-1:0]  s1_delta_r;
  mdd_pkg::stamp_t                       s1_stamp_r;
  logic                                  s1_start_r;

  // series state
  logic signed [W-1:0] equity_r, peak_r, trough_r;
  logic        [W-1:0] deepest_r;
  mdd_pkg::mdd_flags_t flags_r;

  logic signed [W-1:0] equity_nxt, peak_nxt, trough_nxt;
  logic        [W-1:0] deepest_nxt;
  mdd_pkg::mdd_flags_t flags_nxt;
  logic [mdd_pkg::DD_OUT_WIDTH-1:0] dd_nxt;

  // result register
  logic                              out_valid_r;
  logic [mdd_pkg::DD_OUT_WIDTH-1:0]  out_dd_r;
  logic                              out_rec_r;
  mdd_pkg::stamp_t                   out_begin_r;
  mdd_pkg::stamp_t                   out_return_r;

  logic adv;
  logic in_xfer;

  assign adv     = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || adv;
  assign in_xfer = in_chan.valid && in_chan.ready;

  mdd_update #(.SUM_WIDTH(SUM_WIDTH)) u_update (
    .start       (s1_start_r),
    .pnl_delta   (s1_delta_r),
    .stamp       (s1_stamp_r),
    .equity      (equity_r),
    .peak        (peak_r),
    .trough      (trough_r),
    .deepest     (deepest_r),
    .flags       (flags_r),
    .equity_nxt  (equity_nxt),
    .peak_nxt    (peak_nxt),
    .trough_nxt  (trough_nxt),
    .deepest_nxt (deepest_nxt),
    .flags_nxt   (flags_nxt),
    .dd_out      (dd_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_delta_r <= in_chan.pnl_delta;
      s1_stamp_r <= in_chan.stamp;
      s1_start_r <= in_chan.series_start;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      equity_r  <= '0;
      peak_r    <= '0;
      trough_r  <= '0;
      deepest_r <= '0;
      flags_r   <= mdd_pkg::FLAGS_RESET;
    end else if (adv) begin
      equity_r  <= equity_nxt;
      peak_r    <= peak_nxt;
      trough_r  <= trough_nxt;
      deepest_r <= deepest_nxt;
      flags_r   <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_dd_r     <= dd_nxt;
      out_rec_r    <= flags_nxt.any_recovered;
      out_begin_r  <= flags_nxt.begin_stamp;
      out_return_r <= flags_nxt.return_stamp;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.max_drawdown = out_dd_r;
  assign out_chan.recovered    = out_rec_r;
  assign out_chan.drop_begin   = out_begin_r;
  assign out_chan.drop_return  = out_return_r;

  // peak only rises from zero
  a_peak_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
    !peak_r[W-1])
    else $error("peak went negative");

  a_trough_le_peak: assert property (@(posedge clk) disable iff (!rst_n)
    trough_r <= peak_r)
    else $error("trough above peak");

  a_deepest_covers: assert property (@(posedge clk) disable iff (!rst_n)
    deepest_r >= ($unsigned(peak_r) - $unsigned(trough_r)))
    else $error("current drop exceeds deepest");

  a_deepest_mono: assert property (@(posedge clk) disable iff (!rst_n)
    adv && !s1_start_r |=> deepest_r >= $past(deepest_r))
    else $error("deepest fell within a series");

  a_hold_item: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !adv |=> s1_valid_r && $stable(s1_stamp_r))
    else $error("stalled item lost");

endmodule

`default_nettype wire

// ===== test/max_drawdown_tracker_core_tb.sv =====
`default_nettype none

module max_drawdown_tracker_core_tb;

  localparam int PNL_WIDTH    = mdd_pkg::PNL_WIDTH;
  localparam int DD_OUT_WIDTH = mdd_pkg::DD_OUT_WIDTH;
  typedef mdd_pkg::stamp_t stamp_t;

  localparam int SUM_W = mdd_pkg::DEF_SUM_WIDTH;
  localparam logic [63:0] DD_CEIL = (64'd1 << DD_OUT_WIDTH) - 64'd1;
  localparam logic signed [SUM_W-1:0] EQ_HI = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] EQ_LO = {1'b1, {(SUM_W-1){1'b0}}};

  typedef struct packed {
    logic [DD_OUT_WIDTH-1:0] max_drawdown;
    logic                    recovered;
    stamp_t                  drop_begin;
    stamp_t                  drop_return;
  } dd_result_t;

  typedef struct {
    logic signed [PNL_WIDTH-1:0] delta;
    stamp_t                      stamp;
    logic                        start;
    bit                          fixed;
    dd_result_t                  want;
  } deal_row_t;

  localparam dd_result_t NONE = '0;

  logic clk;
  logic rst_n;

  mdd_in_if  in_bus ();
  mdd_out_if out_bus ();

  max_drawdown_tracker_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus)
  );

  // Tracker state mirrored from the block
  logic signed [SUM_W-1:0] equity_acc;
  logic signed [SUM_W-1:0] peak_lvl;
  logic signed [SUM_W-1:0] trough_lvl;
  logic        [SUM_W-1:0] deepest_drop;
  logic                    drop_open;
  stamp_t                  peak_time;
  logic                    first_item;
  logic                    have_recovery;
  stamp_t                  recov_begin;
  stamp_t                  recov_return;

  dd_result_t expected_q[$];
  int         err_count = 0;
  bit         pace_idle = 1'b1;
  int         hold_cnt  = 0;

  // Fixed expectations only where they follow directly from the deltas
  deal_row_t script [20] = '{
    '{32'sd0,            32'd0,          1'b1, 1'b1, '{48'd0, 1'b0, 32'd0, 32'd0}},
    '{32'sh8000_0000,    32'd10,         1'b0, 1'b1, '{48'h8000_0000, 1'b0, 32'd0, 32'd0}},
    '{32'sh7FFF_FFFF,    32'd20,         1'b0, 1'b1, '{48'h8000_0000, 1'b0, 32'd0, 32'd0}},
    '{32'sd1,            32'd30,         1'b0, 1'b1, '{48'h8000_0000, 1'b0, 32'd0, 32'd0}},
    '{32'sd1,            32'd40,         1'b0, 1'b1, '{48'h8000_0000, 1'b1, 32'd0, 32'd40}},
    '{-32'sd5,           32'd50,         1'b0, 1'b0, NONE},
    '{32'sd7,            32'hFFFF_FFFF,  1'b0, 1'b0, NONE},
    '{32'sh7FFF_FFFF,    32'hFFFF_FFFF,  1'b1, 1'b1, '{48'd0, 1'b0, 32'd0, 32'd0}},
    '{32'sh8000_0000,    32'd5,          1'b0, 1'b1, '{48'h8000_0000, 1'b0, 32'd0, 32'd0}},
    '{32'sh7FFF_FFFF,    32'd6,          1'b0, 1'b0, NONE},
    '{32'sd2,            32'd7,          1'b0, 1'b1,
      '{48'h8000_0000, 1'b1, 32'hFFFF_FFFF, 32'd7}},
    '{-32'sd3,           32'hAAAA_5555,  1'b1, 1'b1, '{48'd3, 1'b0, 32'd0, 32'd0}},
    '{32'sd2,            32'h5555_AAAA,  1'b0, 1'b0, NONE},
    '{32'sd2,            32'h0000_1234,  1'b0, 1'b1,
      '{48'd3, 1'b1, 32'hAAAA_5555, 32'h0000_1234}},
    '{-32'sd1,           32'h0000_1235,  1'b0, 1'b0, NONE},
    '{32'sd0,            32'h0000_1236,  1'b0, 1'b0, NONE},
    // new series with flat first item: peak time still comes from it
    '{32'sd0,            32'd99,         1'b1, 1'b1, '{48'd0, 1'b0, 32'd0, 32'd0}},
    '{-32'sd1,           32'd100,        1'b0, 1'b0, NONE},
    '{32'sd1,            32'd101,        1'b0, 1'b0, NONE},
    '{32'sd1,            32'd102,        1'b0, 1'b1, '{48'd1, 1'b1, 32'd99, 32'd102}}
  };

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 19) == 0) return $urandom_range(8, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic void clear_tracker();
    equity_acc    = '0;
    peak_lvl      = '0;
    trough_lvl    = '0;
    deepest_drop  = '0;
    drop_open     = 1'b0;
    peak_time     = '0;
    first_item    = 1'b1;
    have_recovery = 1'b0;
    recov_begin   = '0;
    recov_return  = '0;
  endfunction

  function automatic dd_result_t track_deal(logic signed [PNL_WIDTH-1:0] delta,
                                            stamp_t now, logic start);
    logic signed [SUM_W:0] wide;
    logic [SUM_W-1:0]      drop;
    logic [63:0]           dd64;
    dd_result_t            res;
    if (start) clear_tracker();
    if (first_item) begin
      peak_time  = now;
      first_item = 1'b0;
    end
    wide = {equity_acc[SUM_W-1], equity_acc} + (SUM_W+1)'(delta);
    if (wide[SUM_W] != wide[SUM_W-1]) begin
      equity_acc = wide[SUM_W] ? EQ_LO : EQ_HI;
    end else begin
      equity_acc = wide[SUM_W-1:0];
    end
    if (equity_acc > peak_lvl) begin
      peak_lvl   = equity_acc;
      trough_lvl = equity_acc;
      if (drop_open) begin
        recov_begin   = peak_time;
        recov_return  = now;
        drop_open     = 1'b0;
        have_recovery = 1'b1;
      end
      peak_time = now;
    end else if (trough_lvl > equity_acc) begin
      trough_lvl = equity_acc;
      drop       = peak_lvl - trough_lvl;
      if (drop > deepest_drop) begin
        deepest_drop = drop;
        drop_open    = 1'b1;
      end
    end
    dd64             = 64'(deepest_drop);
    res.max_drawdown = (dd64 > DD_CEIL) ? DD_CEIL[DD_OUT_WIDTH-1:0] : dd64[DD_OUT_WIDTH-1:0];
    res.recovered    = have_recovery;
    res.drop_begin   = recov_begin;
    res.drop_return  = recov_return;
    return res;
  endfunction

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // Drive one deal and return at the edge where it transfers
  task automatic send_deal(input logic signed [PNL_WIDTH-1:0] delta, input stamp_t stamp,
                           input logic start);
    int gap;
    gap = (pace_idle && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.pnl_delta    <= delta;
    in_bus.stamp        <= stamp;
    in_bus.series_start <= start;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic deal(input logic signed [PNL_WIDTH-1:0] delta, input stamp_t stamp,
                      input logic start);
    send_deal(delta, stamp, start);
    expected_q.insert(expected_q.size(), track_deal(delta, stamp, start));
  endtask

  task automatic check_result();
    dd_result_t want;
    if (expected_q.size() == 0) begin
      flag_error("result transfer with nothing expected");
      return;
    end
    want = expected_q[0];
    expected_q.delete(0);
    if (out_bus.max_drawdown !== want.max_drawdown)
      flag_error($sformatf("max_drawdown got %0h want %0h",
                           out_bus.max_drawdown, want.max_drawdown));
    if (out_bus.recovered !== want.recovered)
      flag_error($sformatf("recovered got %b want %b", out_bus.recovered, want.recovered));
    if (out_bus.drop_begin !== want.drop_begin)
      flag_error($sformatf("drop_begin got %0h want %0h",
                           out_bus.drop_begin, want.drop_begin));
    if (out_bus.drop_return !== want.drop_return)
      flag_error($sformatf("drop_return got %0h want %0h",
                           out_bus.drop_return, want.drop_return));
  endtask

  // Result side: check on transfer, then choose ready for the next edge
  always @(posedge clk) begin
    if (rst_n && out_bus.valid && out_bus.ready) check_result();
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_bus.ready <= 1'b0;
      hold_cnt = hold_cnt - 1;
    end else begin
      out_bus.ready <= 1'b1;
      if (pace_idle && $urandom_range(0, 99) < 25) hold_cnt = pick_gap();
    end
  end

  initial begin
    logic signed [PNL_WIDTH-1:0] delta;
    logic [31:0]                 mag;
    logic [31:0]                 span;
    stamp_t                      deal_time;
    dd_result_t                  pred;
    int                          n_sent;
    int                          steps;
    int                          sel;
    bit                          heading;
    bit                          held;

    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.pnl_delta    = '0;
    in_bus.stamp        = '0;
    in_bus.series_start = 1'b0;
    clear_tracker();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      send_deal(script[i].delta, script[i].stamp, script[i].start);
      pred = track_deal(script[i].delta, script[i].stamp, script[i].start);
      expected_q.insert(expected_q.size(), script[i].fixed ? script[i].want : pred);
    end

    // Random walk in episodes of rising or falling runs
    n_sent    = 0;
    held      = 1'b0;
    deal_time = $urandom_range(0, 1000);
    while (n_sent < 560) begin
      steps     = $urandom_range(1, 12);
      heading   = 1'($urandom_range(0, 1));
      sel       = $urandom_range(0, 9);
      span      = (sel < 4) ? 32'd255 : (sel < 8) ? 32'd262143 : 32'h7FFF_FFFF;
      pace_idle = ($urandom_range(0, 4) != 0);
      for (int k = 0; k < steps; k++) begin
        mag = $urandom_range(0, span);
        if ($urandom_range(0, 9) == 0) begin
          delta = $urandom();
        end else if (heading ^ ($urandom_range(0, 4) == 0)) begin
          delta = -$signed(mag);
        end else begin
          delta = $signed(mag);
        end
        deal_time = deal_time + $urandom_range(0, 1000);
        if ($urandom_range(0, 19) == 0) deal_time = $urandom();
        deal(delta, deal_time, $urandom_range(0, 49) == 0);
        n_sent++;
      end
      if (!held && n_sent >= 280) begin
        // drain the pipeline before going on
        held = 1'b1;
        in_bus.valid <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0) @(posedge clk);
      end
    end

    // Large swings back to back: equity well up, then far below zero
    pace_idle = 1'b0;
    deal(32'sh7FFF_FFFF, deal_time, 1'b1);
    for (int k = 0; k < 8; k++) deal(32'sh7FFF_FFFF, deal_time + k, 1'b0);
    for (int k = 0; k < 20; k++) deal(32'sh8000_0000, deal_time - k, 1'b0);
    pace_idle = 1'b1;
    deal(32'sd5, 32'hFFFF_FFFF, 1'b0);
    deal(-32'sd9, 32'h0, 1'b0);

    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(1_500_000 * 8);
    $display("TIMEOUT waiting for transfers");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

// ===== max_drawdown_tracker_core.f =====
hw/rtl/mdd_pkg.sv
hw/rtl/mdd_in_if.sv
hw/rtl/mdd_out_if.sv
hw/rtl/mdd_update.sv
hw/rtl/max_drawdown_tracker_core.sv
test/max_drawdown_tracker_core_tb.sv
